// ===== hw/rtl/tfr_pkg.sv =====
// shared constants and types for the tagged frame receiver
// no dependencies
package tfr_pkg;

  localparam int FRAME_LEN_DEF = 11;

  localparam logic [7:0] HEAD_BYTE = 8'hD8;
  localparam logic [7:0] TAIL_BYTE = 8'hEE;
  localparam logic [7:0] TAG_LEFT  = 8'hB0;
  localparam logic [7:0] TAG_RIGHT = 8'hB1;
  localparam logic [7:0] TAG_STEER = 8'hB2;

  localparam int POS_TAG_LEFT  = 1;
  localparam int POS_TAG_RIGHT = 4;
  localparam int POS_TAG_STEER = 7;

  typedef enum logic [1:0] {
    ST_WAIT     = 2'd0,
    ST_OK       = 2'd1,
    ST_HEAD_ERR = 2'd2,
    ST_TAIL_ERR = 2'd3
  } status_t;

  typedef enum logic {
    REQ_BYTE = 1'b0,
    REQ_SYNC = 1'b1
  } req_t;

endpackage

// ===== hw/rtl/tfr_core.sv =====
// frame store, byte counter, status and decoded value registers
// depends on tfr_pkg
module tfr_core #(
  parameter int FRAME_LEN = tfr_pkg::FRAME_LEN_DEF
) (
  input  logic               clk,
  input  logic               rst,
  input  logic               step_en,
  input  tfr_pkg::req_t      step_req,
  input  logic [7:0]         step_byte,
  output logic signed [15:0] left_count,
  output logic signed [15:0] right_count,
  output logic signed [15:0] steer_value,
  output tfr_pkg::status_t   frame_status,
  output logic               values_updated
);
  import tfr_pkg::*;

  localparam int CNT_W = $clog2(FRAME_LEN);

  logic [CNT_W-1:0] byte_index;
  logic [CNT_W-1:0] byte_index_next;
  logic [CNT_W-1:0] idx_cur;
  logic [7:0]       frame_store [FRAME_LEN];
  status_t          status_reg;
  status_t          status_next;
  logic [15:0]      left_reg, left_next;
  logic [15:0]      right_reg, right_next;
  logic [15:0]      steer_reg, steer_next;
  logic             updated_next;

  // out-of-range counter wraps to the first entry
  always_comb begin
    if ({1'b0, byte_index} >= (CNT_W + 1)'(FRAME_LEN)) begin
      idx_cur = '0;
    end else begin
      idx_cur = byte_index;
    end
  end

  always_comb begin
    byte_index_next = byte_index;
    status_next     = status_reg;
    left_next       = left_reg;
    right_next      = right_reg;
    steer_next      = steer_reg;
    updated_next    = 1'b0;
    unique case (step_req)
      REQ_BYTE: begin
        if (idx_cur == '0 && step_byte != HEAD_BYTE) begin
          byte_index_next = '0;
          status_next     = ST_HEAD_ERR;
        end else if (idx_cur == CNT_W'(FRAME_LEN - 1)) begin
          byte_index_next = '0;
          status_next     = (step_byte == TAIL_BYTE) ? ST_OK : ST_TAIL_ERR;
        end else begin
          byte_index_next = idx_cur + CNT_W'(1);
        end
      end
      REQ_SYNC: begin
        if (status_reg == ST_OK) begin
          if (frame_store[POS_TAG_LEFT] == TAG_LEFT) begin
            left_next = {frame_store[POS_TAG_LEFT + 1], frame_store[POS_TAG_LEFT + 2]};
          end
          if (frame_store[POS_TAG_RIGHT] == TAG_RIGHT) begin
            right_next = {frame_store[POS_TAG_RIGHT + 1], frame_store[POS_TAG_RIGHT + 2]};
          end
          if (frame_store[POS_TAG_STEER] == TAG_STEER) begin
            steer_next = {frame_store[POS_TAG_STEER + 1], frame_store[POS_TAG_STEER + 2]};
          end
          status_next  = ST_WAIT;
          updated_next = 1'b1;
        end
      end
      default: begin
        byte_index_next = byte_index;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      byte_index     <= '0;
      status_reg     <= ST_WAIT;
      left_reg       <= '0;
      right_reg      <= '0;
      steer_reg      <= '0;
      values_updated <= 1'b0;
    end else if (step_en) begin
      byte_index     <= byte_index_next;
      status_reg     <= status_next;
      left_reg       <= left_next;
      right_reg      <= right_next;
      steer_reg      <= steer_next;
      values_updated <= updated_next;
    end
  end

  always_ff @(posedge clk) begin
    if (step_en && step_req == REQ_BYTE) begin
      frame_store[idx_cur] <= step_byte;
    end
  end

  assign left_count   = left_reg;
  assign right_count  = right_reg;
  assign steer_value  = steer_reg;
  assign frame_status = status_reg;

endmodule

// ===== hw/rtl/tagged_frame_receiver_top.sv =====
// top level of the tagged frame receiver: input register, handshake, result hold
// depends on tfr_pkg and tfr_core
// input register, then core registers and out_valid, loaded when output advances
// throughput: one item per cycle, limited only by output backpressure
// the state and value registers double as the result register
// reset: counter, status and values cleared, frame store left unwritten
module tagged_frame_receiver_top #(
  parameter int FRAME_LEN = tfr_pkg::FRAME_LEN_DEF
) (
  input  logic               clk,
  input  logic               rst,
  input  logic               in_valid,
  output logic               in_ready,
  input  logic               req_type,
  input  logic [7:0]         rx_byte,
  output logic               out_valid,
  input  logic               out_ready,
  output logic signed [15:0] left_count,
  output logic signed [15:0] right_count,
  output logic signed [15:0] steer_value,
  output logic [1:0]         frame_status,
  output logic               values_updated
);
  import tfr_pkg::*;

  logic       in_valid_q;
  req_t       req_q;
  logic [7:0] byte_q;
  logic       advance;
  logic       step_en;
  status_t    status_w;

  assign advance  = !out_valid || out_ready;
  assign in_ready = !in_valid_q || advance;
  assign step_en  = in_valid_q && advance;

  always_ff @(posedge clk) begin
    if (rst) begin
      in_valid_q <= 1'b0;
      out_valid  <= 1'b0;
    end else begin
      if (in_ready) begin
        in_valid_q <= in_valid;
      end
      if (advance) begin
        out_valid <= in_valid_q;
      end
    end
  end

  // input transfer register
  always_ff @(posedge clk) begin
    if (in_valid && in_ready) begin
      req_q  <= req_t'(req_type);
      byte_q <= rx_byte;
    end
  end

  tfr_core #(
    .FRAME_LEN(FRAME_LEN)
  ) u_core (
    .clk           (clk),
    .rst           (rst),
    .step_en       (step_en),
    .step_req      (req_q),
    .step_byte     (byte_q),
    .left_count    (left_count),
    .right_count   (right_count),
    .steer_value   (steer_value),
    .frame_status  (status_w),
    .values_updated(values_updated)
  );

  assign frame_status = status_w;

endmodule

// ===== verif/tfr_checker.sv =====
`timescale 1ns / 1ps
// readout checker for the tagged frame receiver: predicts each readout from the input
// transfers and compares it with the output transfers, uses tfr_pkg
module tfr_checker #(
  parameter int FRAME_LEN = tfr_pkg::FRAME_LEN_DEF
) (
  input  logic               clk,
  input  logic               rst,
  input  logic               in_valid,
  input  logic               in_ready,
  input  logic               req_type,
  input  logic [7:0]         rx_byte,
  input  logic               out_valid,
  input  logic               out_ready,
  input  logic signed [15:0] left_count,
  input  logic signed [15:0] right_count,
  input  logic signed [15:0] steer_value,
  input  logic [1:0]         frame_status,
  input  logic               values_updated,
  output int                 mismatches,
  output int                 readouts_due
);
  import tfr_pkg::*;

  typedef struct packed {
    logic signed [15:0] left;
    logic signed [15:0] right;
    logic signed [15:0] steer;
    status_t            status;
    logic               updated;
  } readout_t;

  logic [3:0]         byte_pos;
  logic [7:0]         frame_bytes [FRAME_LEN];
  status_t            status;
  logic signed [15:0] left_val;
  logic signed [15:0] right_val;
  logic signed [15:0] steer_val;
  readout_t           pending_readouts [$];
  readout_t           want;

  initial begin
    mismatches = 0;
    readouts_due = 0;
    foreach (frame_bytes[i]) frame_bytes[i] = 8'h00;
  end

  task automatic report_mismatch(input string what);
    $display("%0t: mismatch: %s", $realtime, what);
    mismatches++;
  endtask

  task automatic check_field(input string name, input logic [15:0] got,
                             input logic [15:0] exp_val);
    if (got !== exp_val) begin
      report_mismatch($sformatf("%s got %h want %h", name, got, exp_val));
    end
  endtask

  task automatic decode_item(input req_t kind, input logic [7:0] data, output readout_t res);
    int  pos;
    logic hit;
    hit = 1'b0;
    if (kind == REQ_BYTE) begin
      pos = (byte_pos >= FRAME_LEN) ? 0 : int'(byte_pos);
      frame_bytes[pos] = data;
      pos++;
      if (pos == 1 && data != HEAD_BYTE) begin
        pos = 0;
        status = ST_HEAD_ERR;
      end
      if (pos == FRAME_LEN) begin
        status = (frame_bytes[FRAME_LEN-1] == TAIL_BYTE) ? ST_OK : ST_TAIL_ERR;
        pos = 0;
      end
      byte_pos = pos[3:0];
    end else if (status == ST_OK) begin
      if (frame_bytes[POS_TAG_LEFT] == TAG_LEFT) begin
        left_val = {frame_bytes[POS_TAG_LEFT+1], frame_bytes[POS_TAG_LEFT+2]};
      end
      if (frame_bytes[POS_TAG_RIGHT] == TAG_RIGHT) begin
        right_val = {frame_bytes[POS_TAG_RIGHT+1], frame_bytes[POS_TAG_RIGHT+2]};
      end
      if (frame_bytes[POS_TAG_STEER] == TAG_STEER) begin
        steer_val = {frame_bytes[POS_TAG_STEER+1], frame_bytes[POS_TAG_STEER+2]};
      end
      status = ST_WAIT;
      hit = 1'b1;
    end
    res.left = left_val;
    res.right = right_val;
    res.steer = steer_val;
    res.status = status;
    res.updated = hit;
  endtask

  always @(posedge clk) begin
    if (rst) begin
      byte_pos = 4'd0;
      status = ST_WAIT;
      left_val = 16'sd0;
      right_val = 16'sd0;
      steer_val = 16'sd0;
      pending_readouts.delete();
    end else begin
      if (in_valid && in_ready) begin
        decode_item(req_t'(req_type), rx_byte, want);
        pending_readouts.push_back(want);
      end
      if (out_valid && out_ready) begin
        if (pending_readouts.size() == 0) begin
          report_mismatch("readout transfer with nothing expected");
        end else begin
          want = pending_readouts.pop_front();
          check_field("left_count", left_count, want.left);
          check_field("right_count", right_count, want.right);
          check_field("steer_value", steer_value, want.steer);
          check_field("frame_status", {14'd0, frame_status}, {14'd0, want.status});
          check_field("values_updated", {15'd0, values_updated}, {15'd0, want.updated});
        end
      end
    end
    readouts_due = pending_readouts.size();
  end

endmodule

// ===== verif/testbench.sv =====
`timescale 1ns / 1ps
// top of the tagged frame receiver testbench: clock, reset, byte and sync stimulus,
// output stalls and the verdict; depends on tfr_pkg, tfr_checker and the block
module testbench;
  import tfr_pkg::*;

  localparam int FRAME_LEN   = FRAME_LEN_DEF;
  localparam int ITEM_TARGET = 1200;
  localparam int CYCLE_LIMIT = 400000;

  logic               clk;
  logic               rst = 1'b1;
  logic               in_valid = 1'b0;
  logic               in_ready;
  logic               req_type = REQ_BYTE;
  logic [7:0]         rx_byte = 8'h00;
  logic               out_valid;
  logic               out_ready = 1'b0;
  logic signed [15:0] left_count;
  logic signed [15:0] right_count;
  logic signed [15:0] steer_value;
  logic [1:0]         frame_status;
  logic               values_updated;

  int   mismatches;
  int   readouts_due;
  int   items_sent = 0;
  int   cycle_count = 0;
  bit   tx_quiet = 1'b0;
  bit   rx_quiet = 1'b0;
  int   ready_gap = 0;
  int   next_gap;

  tagged_frame_receiver_top #(.FRAME_LEN(FRAME_LEN)) i_dut (
    .clk           (clk),
    .rst           (rst),
    .in_valid      (in_valid),
    .in_ready      (in_ready),
    .req_type      (req_type),
    .rx_byte       (rx_byte),
    .out_valid     (out_valid),
    .out_ready     (out_ready),
    .left_count    (left_count),
    .right_count   (right_count),
    .steer_value   (steer_value),
    .frame_status  (frame_status),
    .values_updated(values_updated)
  );

  tfr_checker #(.FRAME_LEN(FRAME_LEN)) i_checker (
    .clk           (clk),
    .rst           (rst),
    .in_valid      (in_valid),
    .in_ready      (in_ready),
    .req_type      (req_type),
    .rx_byte       (rx_byte),
    .out_valid     (out_valid),
    .out_ready     (out_ready),
    .left_count    (left_count),
    .right_count   (right_count),
    .steer_value   (steer_value),
    .frame_status  (frame_status),
    .values_updated(values_updated),
    .mismatches    (mismatches),
    .readouts_due  (readouts_due)
  );

  initial begin
    clk = 1'b0;
    forever #2 clk = ~clk;
  end

  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count == CYCLE_LIMIT) begin
      $display("testbench NOT OK");
      $finish;
    end
  end

  // readout side stalls
  always @(posedge clk) begin
    if (rst) begin
      out_ready <= 1'b0;
      ready_gap <= 0;
    end else if (out_ready && out_valid) begin
      if ($urandom_range(0, 39) == 0) rx_quiet = ~rx_quiet;
      next_gap = rx_quiet ? 0 : $urandom_range(0, 17);
      if (next_gap != 0) begin
        out_ready <= 1'b0;
        ready_gap <= next_gap - 1;
      end
    end else if (!out_ready) begin
      if (ready_gap == 0) begin
        out_ready <= 1'b1;
      end else begin
        ready_gap <= ready_gap - 1;
      end
    end
  end

  task automatic send_item(input req_t kind, input logic [7:0] data);
    int gap;
    gap = tx_quiet ? 0 : $urandom_range(0, 17);
    if (gap != 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid <= 1'b1;
    req_type <= kind;
    rx_byte <= data;
    do @(posedge clk); while (!in_ready);
    items_sent++;
  endtask

  task automatic send_frame(input logic [15:0] lv, input logic [15:0] rv,
                            input logic [15:0] sv, input logic [2:0] tag_ok,
                            input logic tail_ok, input int upto);
    logic [7:0] fb [FRAME_LEN];
    foreach (fb[i]) fb[i] = 8'($urandom_range(0, 255));
    fb[0] = HEAD_BYTE;
    fb[POS_TAG_LEFT] = tag_ok[0] ? TAG_LEFT : TAG_LEFT ^ 8'($urandom_range(1, 255));
    fb[POS_TAG_LEFT+1] = lv[15:8];
    fb[POS_TAG_LEFT+2] = lv[7:0];
    fb[POS_TAG_RIGHT] = tag_ok[1] ? TAG_RIGHT : TAG_RIGHT ^ 8'($urandom_range(1, 255));
    fb[POS_TAG_RIGHT+1] = rv[15:8];
    fb[POS_TAG_RIGHT+2] = rv[7:0];
    fb[POS_TAG_STEER] = tag_ok[2] ? TAG_STEER : TAG_STEER ^ 8'($urandom_range(1, 255));
    fb[POS_TAG_STEER+1] = sv[15:8];
    fb[POS_TAG_STEER+2] = sv[7:0];
    fb[FRAME_LEN-1] = tail_ok ? TAIL_BYTE : TAIL_BYTE ^ 8'($urandom_range(1, 255));
    for (int i = 0; i < upto && i < FRAME_LEN; i++) send_item(REQ_BYTE, fb[i]);
  endtask

  function automatic logic [15:0] pick_value();
    case ($urandom_range(0, 7))
      0: return 16'h8000;
      1: return 16'h7FFF;
      2: return 16'hFFFF;
      3: return 16'h0000;
      default: return 16'($urandom);
    endcase
  endfunction

  function automatic logic [2:0] pick_tags();
    logic [2:0] tags;
    for (int i = 0; i < 3; i++) tags[i] = ($urandom_range(0, 4) != 0);
    return tags;
  endfunction

  initial begin
    int choice;
    repeat (9) @(posedge clk);
    rst <= 1'b0;

    // directed part
    send_item(REQ_SYNC, 8'h00);
    send_item(REQ_BYTE, 8'h00);
    send_frame(16'h8000, 16'h7FFF, 16'hFFFF, 3'b111, 1'b1, FRAME_LEN);
    send_item(REQ_SYNC, 8'hFF);
    send_item(REQ_SYNC, 8'h00);
    send_frame(16'h7FFF, 16'h1234, 16'h8000, 3'b101, 1'b1, FRAME_LEN);
    send_item(REQ_SYNC, 8'h00);

    // random part, mostly well-formed frames
    while (items_sent < ITEM_TARGET) begin
      if ($urandom_range(0, 5) == 0) tx_quiet = ~tx_quiet;
      choice = $urandom_range(0, 19);
      if (choice < 12) begin
        send_frame(pick_value(), pick_value(), pick_value(), pick_tags(),
                   $urandom_range(0, 7) != 0, FRAME_LEN);
        if ($urandom_range(0, 5) != 0) send_item(REQ_SYNC, 8'($urandom));
      end else if (choice < 15) begin
        // partial newer frame overwriting a waiting one
        send_frame(pick_value(), pick_value(), pick_value(), pick_tags(), 1'b1,
                   $urandom_range(1, FRAME_LEN - 1));
        send_item(REQ_SYNC, 8'($urandom));
      end else if (choice < 18) begin
        send_item(REQ_BYTE, 8'($urandom));
      end else begin
        send_item(REQ_SYNC, 8'($urandom));
      end
    end
    in_valid <= 1'b0;

    do @(negedge clk); while (readouts_due != 0);
    repeat (10) @(posedge clk);
    if (mismatches == 0) begin
      $display("testbench OK");
    end else begin
      $display("testbench NOT OK");
    end
    $finish;
  end

endmodule

// ===== filelist.f =====
hw/rtl/tfr_pkg.sv
hw/rtl/tfr_core.sv
hw/rtl/tagged_frame_receiver_top.sv
verif/tfr_checker.sv
verif/testbench.sv
